FILE: src/unit_normal_and_angle_3d_core_assert.svh
// Assertion macros for the unit normal and angle core.
// Define NO_ASSERTIONS to compile them out.
`ifndef UNIT_NORMAL_AND_ANGLE_3D_CORE_ASSERT_SVH
`define UNIT_NORMAL_AND_ANGLE_3D_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UNAN3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UNAN3_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UNAN3_ASSERT(lbl, prop, msg)
`define UNAN3_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/unan3_pkg.sv
package unan3_pkg;

    // Port widths
    localparam int IN_W      = 16;
    localparam int UNIT_W    = 16;
    localparam int ANGLE_W   = 16;

    // Internal widths
    localparam int PROD_W    = 2 * IN_W;          // one component product
    localparam int CM_W      = PROD_W;            // cross / dot magnitude
    localparam int VN_W      = CM_W - 1;          // normalized cross magnitude
    localparam int SQ_W      = 2 * VN_W;          // square of one component
    localparam int SQ_IN_W   = 2 * CM_W;          // sum of squares, root input
    localparam int ROOT_W    = SQ_IN_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int LZ_W      = $clog2(CM_W + 1);
    localparam int SHL_W     = $clog2(CM_W);
    localparam int LEN_W     = $clog2(SQ_IN_W + 1);

    localparam int UNIT_FRAC = 14;
    localparam int UNIT_ONE  = 1 << UNIT_FRAC;
    localparam int QUO_W     = UNIT_FRAC + 2;
    localparam int DIV_N_W   = CM_W + QUO_W - 1;

    localparam int CORDIC_STEPS = 20;
    localparam int TAB_FRAC  = 16;
    localparam int ANGLE_FRAC = 8;
    localparam int XY_W      = CM_W + 4;
    localparam int Z_W       = 25;
    localparam int HALF_TURN_Z    = 180 << TAB_FRAC;
    localparam int QUARTER_TURN_Z = HALF_TURN_Z / 2;
    localparam int ANG_SH    = TAB_FRAC - ANGLE_FRAC;
    localparam int ANG_ROUND = 1 << (ANG_SH - 1);
    localparam int ANGLE_MAX_CODE = (1 << ANGLE_W) - 1;
    localparam int ANGLE_HALF_TURN = 180 << ANGLE_FRAC;

    // Pipeline stage map
    localparam int ST_MUL   = 0;
    localparam int ST_CRS   = 1;
    localparam int ST_MAX   = 2;
    localparam int ST_LZ    = 3;
    localparam int ST_NRM   = 4;
    localparam int ST_SQR   = 5;
    localparam int ST_SUM   = 6;
    localparam int ST_LEN   = 7;
    localparam int ST_SHF   = 8;
    localparam int ST_SQRT  = 9;
    localparam int ST_PREP  = ST_SQRT + SQRT_STEPS;
    localparam int ST_DC    = ST_PREP + 1;
    localparam int ST_OUT   = ST_DC + CORDIC_STEPS;
    localparam int N_STAGES = ST_OUT + 1;

    typedef logic signed [IN_W-1:0]    comp_t;
    typedef logic signed [UNIT_W-1:0]  unit_t;
    typedef logic        [ANGLE_W-1:0] angle_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_PARALLEL = 2'd1,
        STAT_ZERO_LEN = 2'd2
    } status_t;

    typedef struct packed {
        logic [SQ_IN_W-1:0] rem;
        logic [SQ_IN_W-1:0] root;
    } sqrt_pair_t;

    // One digit of the bit-pair square root
    function automatic sqrt_pair_t sqrt_step(input sqrt_pair_t p,
                                             input logic [SQ_IN_W-1:0] bit_w);
        sqrt_pair_t o;
        logic [SQ_IN_W:0] trial;
        trial = {1'b0, p.root} + {1'b0, bit_w};
        if ({1'b0, p.rem} >= trial) begin
            o.rem  = p.rem - trial[SQ_IN_W-1:0];
            o.root = (p.root >> 1) + bit_w;
        end else begin
            o.rem  = p.rem;
            o.root = p.root >> 1;
        end
        return o;
    endfunction

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [Z_W-1:0] atan_deg(input int unsigned i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = Z_W'(2949120);
            1:       v = Z_W'(1740967);
            2:       v = Z_W'(919879);
            3:       v = Z_W'(466945);
            4:       v = Z_W'(234379);
            5:       v = Z_W'(117304);
            6:       v = Z_W'(58666);
            7:       v = Z_W'(29335);
            8:       v = Z_W'(14668);
            9:       v = Z_W'(7334);
            10:      v = Z_W'(3667);
            11:      v = Z_W'(1833);
            12:      v = Z_W'(917);
            13:      v = Z_W'(458);
            14:      v = Z_W'(229);
            15:      v = Z_W'(115);
            16:      v = Z_W'(57);
            17:      v = Z_W'(29);
            18:      v = Z_W'(14);
            19:      v = Z_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/unit_normal_and_angle_3d_core.sv
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    a_x a_y a_z b_x b_y b_z, signed Q8.8
// out      out  out_valid / out_ready  unit_x unit_y unit_z (Q1.14), angle_deg (Q8.8), status
//
// Throughput is one vector pair per cycle unless a stalled output has filled every stage.
// Stages: 9 setup stages, 32 square-root stages (one root bit per stage), one divider
// setup stage, 20 stages that each run one CORDIC step (the first 16 also produce one
// quotient bit), then the output register.
// rst_n clears only the stage valid bits; payload registers carry no reset.
// A stalled output holds its item in place while earlier stages still close up
// bubbles, so in_ready falls only once every stage holds an item.
`include "unit_normal_and_angle_3d_core_assert.svh"

module unit_normal_and_angle_3d_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  unan3_pkg::comp_t  a_x,
    input  unan3_pkg::comp_t  a_y,
    input  unan3_pkg::comp_t  a_z,
    input  unan3_pkg::comp_t  b_x,
    input  unan3_pkg::comp_t  b_y,
    input  unan3_pkg::comp_t  b_z,
    output logic              out_valid,
    input  logic              out_ready,
    output unan3_pkg::unit_t  unit_x,
    output unan3_pkg::unit_t  unit_y,
    output unan3_pkg::unit_t  unit_z,
    output unan3_pkg::angle_t angle_deg,
    output unan3_pkg::status_t status
);
    import unan3_pkg::*;

    typedef struct packed {
        logic signed [PROD_W-1:0] p_yz;
        logic signed [PROD_W-1:0] p_zy;
        logic signed [PROD_W-1:0] p_zx;
        logic signed [PROD_W-1:0] p_xz;
        logic signed [PROD_W-1:0] p_xy;
        logic signed [PROD_W-1:0] p_yx;
        logic signed [PROD_W-1:0] p_xx;
        logic signed [PROD_W-1:0] p_yy;
        logic signed [PROD_W-1:0] p_zz;
        logic                     zero_in;
    } mul_t;

    typedef struct packed {
        logic [2:0][CM_W-1:0] cm;
        logic [2:0]           cneg;
        logic [CM_W-1:0]      dmag;
        logic                 dneg;
        logic                 zero_in;
    } crs_t;

    typedef struct packed {
        crs_t            c;
        logic [CM_W-1:0] cmax;
    } max_t;

    typedef struct packed {
        crs_t             c;
        logic [LZ_W-1:0]  lz;
        logic             wide;
        status_t          stat;
    } lz_t;

    // Fields that ride along to the divider setup
    typedef struct packed {
        logic [2:0][VN_W-1:0] v;
        logic [2:0]           cneg;
        logic                 dneg;
        status_t              stat;
    } carry_t;

    typedef struct packed {
        carry_t               ctl;
        logic [2:0][VN_W-1:0] va;
        logic [CM_W-1:0]      dk;
    } nrm_t;

    typedef struct packed {
        carry_t               ctl;
        logic [2:0][SQ_W-1:0] sqv;
        logic [2:0][SQ_W-1:0] sqa;
        logic [CM_W-1:0]      dk;
    } sqr_t;

    typedef struct packed {
        carry_t             ctl;
        logic [SQ_IN_W-1:0] m2n;
        logic [SQ_IN_W-1:0] m2a;
        logic [CM_W-1:0]    dk;
    } sum_t;

    typedef struct packed {
        sum_t             s;
        logic [LZ_W-1:0]  len_dk;
        logic [LEN_W-1:0] len_m2a;
    } len_t;

    typedef struct packed {
        carry_t          ctl;
        sqrt_pair_t      nrm;
        sqrt_pair_t      ang;
        logic [CM_W-1:0] xs;
    } sq_t;

    typedef struct packed {
        logic [2:0][DIV_N_W-1:0] rem;
        logic [2:0][QUO_W-1:0]   quo;
        logic [ROOT_W-1:0]       dvs;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
        logic [2:0]              cneg;
        logic                    dneg;
        status_t                 stat;
    } dc_t;

    // One root bit for both roots
    function automatic sq_t sqrt_stage(input sq_t s, input int j);
        sq_t o;
        logic [SQ_IN_W-1:0] bit_w;
        o     = s;
        bit_w = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * j);
        o.nrm = sqrt_step(s.nrm, bit_w);
        o.ang = sqrt_step(s.ang, bit_w);
        return o;
    endfunction

    // One CORDIC vectoring step, plus one quotient bit per lane in the first QUO_W steps
    function automatic dc_t dc_stage(input dc_t s, input int t);
        dc_t o;
        logic [DIV_N_W-1:0] dsh;
        logic signed [XY_W-1:0] xsh;
        logic signed [XY_W-1:0] ysh;
        o = s;
        if (t < QUO_W) begin
            dsh = DIV_N_W'(s.dvs) << (QUO_W - 1 - t);
            for (int i = 0; i < 3; i++) begin
                if (s.rem[i] >= dsh) begin
                    o.rem[i] = s.rem[i] - dsh;
                    o.quo[i][QUO_W-1-t] = 1'b1;
                end
            end
        end
        xsh = s.x >>> t;
        ysh = s.y >>> t;
        if (s.y > 0) begin
            o.x = s.x + ysh;
            o.y = s.y - xsh;
            o.z = s.z + atan_deg(t);
        end else if (s.y < 0) begin
            o.x = s.x - ysh;
            o.y = s.y + xsh;
            o.z = s.z - atan_deg(t);
        end
        return o;
    endfunction

    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] en;

    mul_t mul_reg, mul_next;
    crs_t crs_reg, crs_next;
    max_t max_reg, max_next;
    lz_t  lz_reg,  lz_next;
    nrm_t nrm_reg, nrm_next;
    sqr_t sqr_reg, sqr_next;
    sum_t sum_reg, sum_next;
    len_t len_reg, len_next;
    sq_t  shf_reg, shf_next;
    sq_t  sq_reg  [SQRT_STEPS];
    sq_t  sq_next [SQRT_STEPS];
    dc_t  prep_reg, prep_next;
    dc_t  dc_reg  [CORDIC_STEPS];
    dc_t  dc_next [CORDIC_STEPS];

    unit_t   unit_x_reg, unit_x_next;
    unit_t   unit_y_reg, unit_y_next;
    unit_t   unit_z_reg, unit_z_next;
    angle_t  angle_reg,  angle_next;
    status_t status_reg, status_next;

    // A stage advances when it is empty or any later stage (or the output) frees up
    always_comb begin
        for (int i = 0; i < N_STAGES; i++) begin
            en[i] = out_ready || (|(~vld_reg & ({N_STAGES{1'b1}} << i)));
        end
    end

    assign in_ready  = en[ST_MUL];
    assign out_valid = vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < N_STAGES; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 1: all nine component products and the zero-input flag
    always_comb begin
        mul_next.p_yz = PROD_W'(a_y) * PROD_W'(b_z);
        mul_next.p_zy = PROD_W'(a_z) * PROD_W'(b_y);
        mul_next.p_zx = PROD_W'(a_z) * PROD_W'(b_x);
        mul_next.p_xz = PROD_W'(a_x) * PROD_W'(b_z);
        mul_next.p_xy = PROD_W'(a_x) * PROD_W'(b_y);
        mul_next.p_yx = PROD_W'(a_y) * PROD_W'(b_x);
        mul_next.p_xx = PROD_W'(a_x) * PROD_W'(b_x);
        mul_next.p_yy = PROD_W'(a_y) * PROD_W'(b_y);
        mul_next.p_zz = PROD_W'(a_z) * PROD_W'(b_z);
        mul_next.zero_in = (a_x == '0 && a_y == '0 && a_z == '0)
                        || (b_x == '0 && b_y == '0 && b_z == '0);
    end

    // Stage 2: cross product and dot product, split into sign and magnitude
    always_comb begin : p_crs
        logic signed [PROD_W:0]   c [3];
        logic signed [PROD_W+1:0] dot;
        c[0] = (PROD_W+1)'(mul_reg.p_yz) - (PROD_W+1)'(mul_reg.p_zy);
        c[1] = (PROD_W+1)'(mul_reg.p_zx) - (PROD_W+1)'(mul_reg.p_xz);
        c[2] = (PROD_W+1)'(mul_reg.p_xy) - (PROD_W+1)'(mul_reg.p_yx);
        dot  = (PROD_W+2)'(mul_reg.p_xx) + (PROD_W+2)'(mul_reg.p_yy)
             + (PROD_W+2)'(mul_reg.p_zz);
        for (int i = 0; i < 3; i++) begin
            crs_next.cneg[i] = c[i][PROD_W];
            crs_next.cm[i]   = CM_W'(c[i][PROD_W] ? -c[i] : c[i]);
        end
        crs_next.dneg    = dot[PROD_W+1];
        crs_next.dmag    = CM_W'(dot[PROD_W+1] ? -dot : dot);
        crs_next.zero_in = mul_reg.zero_in;
    end

    // Stage 3: largest cross magnitude
    always_comb begin : p_max
        logic [CM_W-1:0] m01;
        m01 = (crs_reg.cm[0] > crs_reg.cm[1]) ? crs_reg.cm[0] : crs_reg.cm[1];
        max_next.c    = crs_reg;
        max_next.cmax = (crs_reg.cm[2] > m01) ? crs_reg.cm[2] : m01;
    end

    // Stage 4: leading zeros of the largest magnitude, classify the item
    always_comb begin
        lz_next.c    = max_reg.c;
        lz_next.lz   = LZ_W'(CM_W);
        for (int i = 0; i < CM_W; i++) begin
            if (max_reg.cmax[i]) begin
                lz_next.lz = LZ_W'(CM_W - 1 - i);
            end
        end
        lz_next.wide = max_reg.cmax[CM_W-1];
        if (max_reg.c.zero_in) begin
            lz_next.stat = STAT_ZERO_LEN;
        end else if (max_reg.cmax == '0) begin
            lz_next.stat = STAT_PARALLEL;
        end else begin
            lz_next.stat = STAT_OK;
        end
    end

    // Stage 5: scale the cross product so its top component sits just below the top bit
    always_comb begin : p_nrm
        logic [SHL_W-1:0] shl;
        shl = SHL_W'(lz_reg.lz - LZ_W'(1));
        for (int i = 0; i < 3; i++) begin
            nrm_next.ctl.v[i] = lz_reg.wide ? VN_W'(lz_reg.c.cm[i] >> 1)
                                            : VN_W'(lz_reg.c.cm[i] << shl);
            nrm_next.va[i]    = lz_reg.wide ? VN_W'(lz_reg.c.cm[i] >> 1)
                                            : VN_W'(lz_reg.c.cm[i]);
        end
        nrm_next.dk       = lz_reg.wide ? (lz_reg.c.dmag >> 1) : lz_reg.c.dmag;
        nrm_next.ctl.cneg = lz_reg.c.cneg;
        nrm_next.ctl.dneg = lz_reg.c.dneg;
        nrm_next.ctl.stat = lz_reg.stat;
    end

    // Stage 6: squares
    always_comb begin
        sqr_next.ctl = nrm_reg.ctl;
        sqr_next.dk  = nrm_reg.dk;
        for (int i = 0; i < 3; i++) begin
            sqr_next.sqv[i] = SQ_W'(nrm_reg.ctl.v[i]) * SQ_W'(nrm_reg.ctl.v[i]);
            sqr_next.sqa[i] = SQ_W'(nrm_reg.va[i]) * SQ_W'(nrm_reg.va[i]);
        end
    end

    // Stage 7: sums of squares
    always_comb begin
        sum_next.ctl = sqr_reg.ctl;
        sum_next.dk  = sqr_reg.dk;
        sum_next.m2n = SQ_IN_W'(sqr_reg.sqv[0]) + SQ_IN_W'(sqr_reg.sqv[1])
                     + SQ_IN_W'(sqr_reg.sqv[2]);
        sum_next.m2a = SQ_IN_W'(sqr_reg.sqa[0]) + SQ_IN_W'(sqr_reg.sqa[1])
                     + SQ_IN_W'(sqr_reg.sqa[2]);
    end

    // Stage 8: bit lengths for the CORDIC input scaling
    always_comb begin
        len_next.s       = sum_reg;
        len_next.len_dk  = '0;
        len_next.len_m2a = '0;
        for (int i = 0; i < CM_W; i++) begin
            if (sum_reg.dk[i]) begin
                len_next.len_dk = LZ_W'(i + 1);
            end
        end
        for (int i = 0; i < SQ_IN_W; i++) begin
            if (sum_reg.m2a[i]) begin
                len_next.len_m2a = LEN_W'(i + 1);
            end
        end
    end

    // Stage 9: common left shift s of dot (by s) and squared length (by 2s), or right shifts by 1 and 2 when too long
    always_comb begin : p_shf
        logic             big;
        logic [LEN_W-1:0] s_a;
        logic [LEN_W-1:0] s_b;
        logic [LEN_W-1:0] sh;
        big = len_reg.len_m2a > LEN_W'(SQ_IN_W - 2);
        s_a = LEN_W'(CM_W) - LEN_W'(len_reg.len_dk);
        s_b = (LEN_W'(SQ_IN_W - 2) - len_reg.len_m2a) >> 1;
        sh  = LEN_W'(CM_W - 1);
        if (s_a < sh) begin
            sh = s_a;
        end
        if (s_b < sh) begin
            sh = s_b;
        end
        shf_next.ctl      = len_reg.s.ctl;
        shf_next.nrm.rem  = len_reg.s.m2n;
        shf_next.nrm.root = '0;
        shf_next.ang.root = '0;
        if (big) begin
            shf_next.xs      = len_reg.s.dk >> 1;
            shf_next.ang.rem = len_reg.s.m2a >> 2;
        end else begin
            shf_next.xs      = len_reg.s.dk << sh[SHL_W-1:0];
            shf_next.ang.rem = len_reg.s.m2a << {sh[SHL_W-1:0], 1'b0};
        end
    end

    // Square-root stages
    always_comb begin
        sq_next[0] = sqrt_stage(shf_reg, 0);
        for (int j = 1; j < SQRT_STEPS; j++) begin
            sq_next[j] = sqrt_stage(sq_reg[j-1], j);
        end
    end

    // Divider setup: numerator v * 2^14 + m / 2, CORDIC start vector (|dot|, |cross|)
    always_comb begin : p_prep
        logic [ROOT_W-1:0] m;
        m = sq_reg[SQRT_STEPS-1].nrm.root[ROOT_W-1:0];
        for (int i = 0; i < 3; i++) begin
            prep_next.rem[i] = (DIV_N_W'(sq_reg[SQRT_STEPS-1].ctl.v[i]) << UNIT_FRAC)
                             + DIV_N_W'(m >> 1);
        end
        prep_next.quo  = '0;
        prep_next.dvs  = m;
        prep_next.x    = $signed(XY_W'(sq_reg[SQRT_STEPS-1].xs));
        prep_next.y    = $signed(XY_W'(sq_reg[SQRT_STEPS-1].ang.root[ROOT_W-1:0]));
        prep_next.z    = '0;
        prep_next.cneg = sq_reg[SQRT_STEPS-1].ctl.cneg;
        prep_next.dneg = sq_reg[SQRT_STEPS-1].ctl.dneg;
        prep_next.stat = sq_reg[SQRT_STEPS-1].ctl.stat;
    end

    // Divide / CORDIC stages
    always_comb begin
        dc_next[0] = dc_stage(prep_reg, 0);
        for (int t = 1; t < CORDIC_STEPS; t++) begin
            dc_next[t] = dc_stage(dc_reg[t-1], t);
        end
    end

    // Output stage: clamp, apply signs, map the angle to the output code
    always_comb begin : p_out
        dc_t                   d;
        logic [QUO_W-1:0]      u [3];
        unit_t                 un [3];
        logic signed [Z_W-1:0] zc;
        logic [Z_W-1:0]        q;
        d = dc_reg[CORDIC_STEPS-1];
        for (int i = 0; i < 3; i++) begin
            u[i]  = (d.quo[i] > QUO_W'(UNIT_ONE)) ? QUO_W'(UNIT_ONE) : d.quo[i];
            un[i] = d.cneg[i] ? (UNIT_W'(0) - UNIT_W'(u[i])) : UNIT_W'(u[i]);
            if (d.stat != STAT_OK) begin
                un[i] = '0;
            end
        end
        zc = d.z;
        if (zc < 0) begin
            zc = '0;
        end
        if (zc > Z_W'(QUARTER_TURN_Z)) begin
            zc = Z_W'(QUARTER_TURN_Z);
        end
        if (d.dneg) begin
            zc = Z_W'(HALF_TURN_Z) - zc;
        end
        if (d.stat == STAT_PARALLEL) begin
            zc = d.dneg ? Z_W'(HALF_TURN_Z) : '0;
        end
        q = Z_W'(zc + Z_W'(ANG_ROUND)) >> ANG_SH;
        if (q > Z_W'(ANGLE_MAX_CODE)) begin
            q = Z_W'(ANGLE_MAX_CODE);
        end
        unit_x_next = un[0];
        unit_y_next = un[1];
        unit_z_next = un[2];
        angle_next  = (d.stat == STAT_ZERO_LEN) ? '0 : q[ANGLE_W-1:0];
        status_next = d.stat;
    end

    // Payload registers: load on stage advance, no reset
    always_ff @(posedge clk) begin
        if (en[ST_MUL]) mul_reg <= mul_next;
        if (en[ST_CRS]) crs_reg <= crs_next;
        if (en[ST_MAX]) max_reg <= max_next;
        if (en[ST_LZ])  lz_reg  <= lz_next;
        if (en[ST_NRM]) nrm_reg <= nrm_next;
        if (en[ST_SQR]) sqr_reg <= sqr_next;
        if (en[ST_SUM]) sum_reg <= sum_next;
        if (en[ST_LEN]) len_reg <= len_next;
        if (en[ST_SHF]) shf_reg <= shf_next;
        for (int j = 0; j < SQRT_STEPS; j++) begin
            if (en[ST_SQRT+j]) sq_reg[j] <= sq_next[j];
        end
        if (en[ST_PREP]) prep_reg <= prep_next;
        for (int t = 0; t < CORDIC_STEPS; t++) begin
            if (en[ST_DC+t]) dc_reg[t] <= dc_next[t];
        end
        if (en[ST_OUT]) begin
            unit_x_reg <= unit_x_next;
            unit_y_reg <= unit_y_next;
            unit_z_reg <= unit_z_next;
            angle_reg  <= angle_next;
            status_reg <= status_next;
        end
    end

    assign unit_x    = unit_x_reg;
    assign unit_y    = unit_y_reg;
    assign unit_z    = unit_z_reg;
    assign angle_deg = angle_reg;
    assign status    = status_reg;

    // Result shapes checked below
    logic unit_zero, out_cleared, angle_edge, angle_in_range;
    logic out_zero_len, out_parallel, out_ok;
    assign unit_zero      = unit_x == '0 && unit_y == '0 && unit_z == '0;
    assign out_cleared    = unit_zero && angle_deg == '0;
    assign angle_edge     = angle_deg == '0 || angle_deg == ANGLE_W'(ANGLE_HALF_TURN);
    assign angle_in_range = angle_deg <= ANGLE_W'(ANGLE_HALF_TURN);
    assign out_zero_len   = out_valid && status == STAT_ZERO_LEN;
    assign out_parallel   = out_valid && status == STAT_PARALLEL;
    assign out_ok         = out_valid && status == STAT_OK;

    `UNAN3_ASSERT_ALWAYS(a_rst_empty, !rst_n |-> vld_reg == '0, "stages hold items in reset")
    `UNAN3_ASSERT(a_full_stall, !in_ready |-> (&vld_reg), "input stalled with an empty stage")
    `UNAN3_ASSERT(a_zero_len, out_zero_len |-> out_cleared, "zero-length result not cleared")
    `UNAN3_ASSERT(a_parallel, out_parallel |-> unit_zero && angle_edge, "parallel result malformed")
    `UNAN3_ASSERT(a_angle_range, out_ok |-> angle_in_range, "angle above half turn")

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import unan3_pkg::*;

    typedef struct {
        unit_t   ux;
        unit_t   uy;
        unit_t   uz;
        angle_t  ang;
        status_t st;
    } normal_angle_t;

    localparam int STALL_LIMIT = 3000;   // cycles with no transfer before giving up
    localparam int DRAIN_WAIT  = 100;    // allow margin after the last result

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    comp_t   a_x, a_y, a_z, b_x, b_y, b_z;
    logic    out_valid;
    logic    out_ready;
    unit_t   unit_x, unit_y, unit_z;
    angle_t  angle_deg;
    status_t status;

    normal_angle_t expected_q[$];
    int  error_count;
    int  idle_cycles;
    bit  send_gaps;      // sender inserts random gaps when set
    bit  sink_stalls;    // receiver drops ready at random when set

    unit_normal_and_angle_3d_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
        .angle_deg(angle_deg), .status(status)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Integer square root, floor, bit-pair method
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint atan_step_deg(input int i);
        longint tab [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                             29, 14, 7};
        return tab[i];
    endfunction

    // Round degrees from 16 fraction bits down to the port's 8, saturate
    function automatic angle_t deg_to_code(input longint z);
        longint unsigned q;
        q = (longint'(z) + 128) >> 8;
        return (q > 64'hFFFF) ? 16'hFFFF : angle_t'(q);
    endfunction

    // Unit normal of a x b and the angle between a and b
    function automatic normal_angle_t calc_normal_angle(input comp_t ax, ay, az,
                                                        input comp_t bx, by, bz);
        normal_angle_t   res;
        longint          a [3];
        longint          b [3];
        longint          c [3];
        longint          p;
        longint unsigned cm [3];
        longint unsigned v [3];
        longint unsigned cmax, pos, neg, dmag, dk, m, m2, xs, ys, u;
        longint          x, y, xn, yn, z, full;
        bit              dneg;
        int              k, s, sh;

        a = '{longint'(ax), longint'(ay), longint'(az)};
        b = '{longint'(bx), longint'(by), longint'(bz)};
        res = '{0, 0, 0, 0, STAT_OK};
        full = 64'sd180 <<< 16;
        if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0))
        begin
            res.st = STAT_ZERO_LEN;
            return res;
        end
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        cmax = 0;
        pos = 0;
        neg = 0;
        for (int i = 0; i < 3; i++)
        begin
            p = a[i] * b[i];
            cm[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
            if (cm[i] > cmax)
                cmax = cm[i];
            if (p >= 0)
                pos += p;
            else
                neg += -p;
        end
        dneg = neg > pos;
        dmag = dneg ? neg - pos : pos - neg;

        if (cmax == 0)
        begin
            res.ang = dneg ? deg_to_code(full) : '0;
            res.st  = STAT_PARALLEL;
            return res;
        end

        // Scale so the largest component lies in [2^30, 2^31)
        sh = 0;
        if (cmax >= (64'd1 << 31))
        begin
            while ((cmax >> sh) >= (64'd1 << 31))
                sh++;
            for (int i = 0; i < 3; i++)
                v[i] = cm[i] >> sh;
        end
        else
        begin
            while ((cmax << sh) < (64'd1 << 30))
                sh++;
            for (int i = 0; i < 3; i++)
                v[i] = cm[i] << sh;
        end
        m = int_sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        for (int i = 0; i < 3; i++)
        begin
            u = (v[i] * 16384 + m / 2) / m;
            if (u > 16384)
                u = 16384;
            if (i == 0) res.ux = (c[i] < 0) ? -unit_t'(u) : unit_t'(u);
            if (i == 1) res.uy = (c[i] < 0) ? -unit_t'(u) : unit_t'(u);
            if (i == 2) res.uz = (c[i] < 0) ? -unit_t'(u) : unit_t'(u);
        end

        // atan2(|a x b|, a.b) by vectoring CORDIC
        k = 0;
        while ((cmax >> k) >= (64'd1 << 31) || (dmag >> k) >= (64'd1 << 33))
            k++;
        for (int i = 0; i < 3; i++)
            v[i] = cm[i] >> k;
        m2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        dk = dmag >> k;
        for (s = 31; s > -1; s--)
            if ((dk >> (32 - s)) == 0 && (m2 >> (62 - 2 * s)) == 0)
                break;
        if (s >= 0)
        begin
            xs = dk << s;
            ys = int_sqrt(m2 << (2 * s));
        end
        else
        begin
            xs = dk >> 1;
            ys = int_sqrt(m2 >> 2);
        end
        x = longint'(xs);
        y = longint'(ys);
        z = 0;
        for (int i = 0; i < 20; i++)
        begin
            if (y == 0)
                break;
            if (y > 0)
            begin
                xn = x + (y >>> i);
                yn = y - (x >>> i);
                z += atan_step_deg(i);
            end
            else
            begin
                xn = x - (y >>> i);
                yn = y + (x >>> i);
                z -= atan_step_deg(i);
            end
            x = xn;
            y = yn;
        end
        if (z < 0)
            z = 0;
        if (z > full / 2)
            z = full / 2;
        if (dneg)
            z = full - z;
        res.ang = deg_to_code(z);
        return res;
    endfunction

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Transfer one vector pair; hold valid and payload until accepted
    task automatic send_pair(input comp_t ax, ay, az, bx, by, bz);
        int gap;
        @(negedge clk);
        a_x = ax; a_y = ay; a_z = az;
        b_x = bx; b_y = by; b_z = bz;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_q.push_back(calc_normal_angle(ax, ay, az, bx, by, bz));
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        go_idle();
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic comp_t rand_comp();
        return comp_t'($urandom());
    endfunction

    // Zero-length inputs on either side and on both
    task automatic test_zero_length();
        send_pair(0, 0, 0, 256, 0, 0);
        send_pair(-32768, 32767, 1, 0, 0, 0);
        send_pair(0, 0, 0, 0, 0, 0);
    endtask

    // Parallel and antiparallel pairs, including the extremes
    task automatic test_parallel();
        send_pair(256, 512, -768, 512, 1024, -1536);
        send_pair(256, 512, -768, -256, -512, 768);
        send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
        send_pair(32767, 32767, 32767, -32767, -32767, -32767);
        send_pair(1, 0, 0, -32768, 0, 0);
    endtask

    // Extreme component values, orthogonal axes and near-parallel pairs
    task automatic test_extremes();
        send_pair(256, 0, 0, 0, 256, 0);
        send_pair(0, 256, 0, 0, 0, -256);
        send_pair(32767, -32768, 32767, -32768, 32767, -32768);
        send_pair(-32768, 32767, 0, 32767, 32767, -32768);
        send_pair(-32768, -32768, 32767, 32767, -32768, -32768);
        send_pair(1, 1, 1, -1, 1, 0);
        send_pair(32767, 32767, 32766, 32767, 32767, 32767);
        send_pair(-32768, -32768, -32767, 32767, 32767, 32767);
        send_pair(1, 0, 0, 32767, 1, 0);
        send_pair(-1, 0, 0, 32767, 1, 0);
        send_pair(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0);
    endtask

    // Random pairs with a mix of shapes
    task automatic test_random(input int count);
        comp_t ax, ay, az, bx, by, bz;
        int    shape;
        int    scale;
        for (int n = 0; n < count; n++)
        begin
            ax = rand_comp(); ay = rand_comp(); az = rand_comp();
            bx = rand_comp(); by = rand_comp(); bz = rand_comp();
            shape = $urandom_range(0, 9);
            case (shape)
                0:  // small components
                begin
                    ax = $urandom_range(0, 8) - 4; ay = $urandom_range(0, 8) - 4;
                    az = $urandom_range(0, 8) - 4; bx = $urandom_range(0, 8) - 4;
                    by = $urandom_range(0, 8) - 4; bz = $urandom_range(0, 8) - 4;
                end
                1:  // b is a scaled copy of a
                begin
                    scale = int'($urandom_range(0, 8)) - 4;
                    ax = $urandom_range(0, 4000) - 2000;
                    ay = $urandom_range(0, 4000) - 2000;
                    az = $urandom_range(0, 4000) - 2000;
                    bx = ax * scale; by = ay * scale; bz = az * scale;
                end
                2:  // one vector zero
                begin
                    if ($urandom_range(0, 1))
                        {ax, ay, az} = '0;
                    else
                        {bx, by, bz} = '0;
                end
                3:  // near-parallel
                begin
                    bx = ax + $urandom_range(0, 2) - 1;
                    by = ay;
                    bz = az + $urandom_range(0, 2) - 1;
                end
                4:  // components at the extremes
                begin
                    ax = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    by = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    bz = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                end
                default: ;
            endcase
            send_pair(ax, ay, az, bx, by, bz);
        end
    endtask

    // Hold the sender until the pipeline has emptied, then go on
    task automatic test_drain_pause();
        test_random(40);
        wait_drained();
        test_random(40);
    endtask

    // Receiver ready: random stalls when enabled, always ready otherwise
    always @(negedge clk)
    begin
        if (!sink_stalls)
            out_ready = 1'b1;
        else if ($urandom_range(0, 99) < 6)
            out_ready = 1'b0;
        else if (!out_ready && $urandom_range(0, 99) < 85)
            out_ready = out_ready;   // hold the stall for a while
        else
            out_ready = ($urandom_range(0, 99) < 75);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        normal_angle_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no expectation pending");
                error_count++;
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (unit_x !== exp_res.ux)
                begin
                    $error("unit_x expected %0d actual %0d", exp_res.ux, unit_x);
                    error_count++;
                end
                if (unit_y !== exp_res.uy)
                begin
                    $error("unit_y expected %0d actual %0d", exp_res.uy, unit_y);
                    error_count++;
                end
                if (unit_z !== exp_res.uz)
                begin
                    $error("unit_z expected %0d actual %0d", exp_res.uz, unit_z);
                    error_count++;
                end
                if (angle_deg !== exp_res.ang)
                begin
                    $error("angle_deg expected %0d actual %0d", exp_res.ang, angle_deg);
                    error_count++;
                end
                if (status !== exp_res.st)
                begin
                    $error("status expected %0d actual %0d", exp_res.st, status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        send_gaps   = 1'b0;
        sink_stalls = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        {a_x, a_y, a_z, b_x, b_y, b_z} = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part back to back, then with stalls on the receiver
        test_zero_length();
        test_parallel();
        sink_stalls = 1'b1;
        test_extremes();
        send_gaps = 1'b1;
        test_drain_pause();
        // Random part: a stretch with no idling, then idling on both sides, then receiver stalls only
        send_gaps   = 1'b0;
        sink_stalls = 1'b0;
        test_random(300);
        send_gaps   = 1'b1;
        sink_stalls = 1'b1;
        test_random(1000);
        send_gaps = 1'b0;
        test_random(350);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
